// ===== hw/rtl/oli_pkg.sv =====
// Package with request kinds, status codes and the store command type for the ordered list.
package oli_pkg;

  localparam int KIND_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_IN_W = 6;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 2;
  localparam int LEN_W    = 5;

  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_REAR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOB   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic              we;
    logic              ins;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } store_op_t;

endpackage

// ===== hw/rtl/oli_store.sv =====
// Row of entry registers that shift by one place on an insert or a delete.
module oli_store #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  oli_pkg::store_op_t          op,
  output logic [oli_pkg::DATA_W-1:0]  rd_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [oli_pkg::DATA_W-1:0] entries_r   [CAPACITY];
  logic [oli_pkg::DATA_W-1:0] entries_nxt [CAPACITY];

  assign rd_data = entries_r[op.pos[IDX_W-1:0]];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [oli_pkg::POS_W-1:0] IDX = oli_pkg::POS_W'(g);
    localparam int BELOW = (g > 0) ? g - 1 : 0;
    localparam int ABOVE = (g + 1 < CAPACITY) ? g + 1 : g;

    always_comb begin
      if (IDX < op.pos) begin
        entries_nxt[g] = entries_r[g];
      end else if (op.ins) begin
        if (IDX == op.pos) begin
          entries_nxt[g] = op.value;
        end else begin
          entries_nxt[g] = entries_r[BELOW];
        end
      end else begin
        entries_nxt[g] = entries_r[ABOVE];
      end
    end

    always_ff @(posedge clk) begin
      if (op.we) begin
        entries_r[g] <= entries_nxt[g];
      end
    end
  end

endmodule

// ===== hw/rtl/ordered_list_insert_delete.sv =====
// Top level of the ordered list store with front, rear and indexed insert and delete.
//
//   Channel | Direction | Ports                                    | Handshake
//   in      | request   | in_kind, in_value, in_position           | in_valid / in_stall
//   out     | result    | out_status, out_item_value, out_length   | out_valid / out_stall
//
// A word is registered at the input, then decoded and applied, and its result is
// registered at the output. One word is taken every cycle while the output does not
// stall; all entries shift by at most one place in parallel.
// Reset clears the entry count and both valid flags; entry contents need no reset.
// A stall on the output holds the result register; an empty input register still
// takes one word, and a full one stalls the input.
module ordered_list_insert_delete #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [oli_pkg::KIND_W-1:0]    in_kind,
  input  logic signed [oli_pkg::DATA_W-1:0] in_value,
  input  logic [oli_pkg::POS_IN_W-1:0]  in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [oli_pkg::STAT_W-1:0]    out_status,
  output logic signed [oli_pkg::DATA_W-1:0] out_item_value,
  output logic [oli_pkg::LEN_W-1:0]     out_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [oli_pkg::POS_W-1:0] CAP_P = oli_pkg::POS_W'(CAPACITY);

  logic                            s1_valid_r;
  logic [oli_pkg::KIND_W-1:0]      s1_kind_r;
  logic [oli_pkg::DATA_W-1:0]      s1_value_r;
  logic [oli_pkg::POS_IN_W-1:0]    s1_pos_r;
  logic [CNT_W-1:0]                count_r;
  logic [CNT_W-1:0]                count_nxt;
  logic                            out_valid_r;
  logic [oli_pkg::STAT_W-1:0]      status_r;
  logic [oli_pkg::STAT_W-1:0]      status_nxt;
  logic [oli_pkg::DATA_W-1:0]      item_r;
  logic [oli_pkg::DATA_W-1:0]      item_nxt;
  logic [oli_pkg::LEN_W-1:0]       length_r;

  logic                            advance;
  logic                            s1_load;
  logic                            do_ins;
  logic                            do_del;
  logic [oli_pkg::POS_W-1:0]       cnt_p;
  logic [oli_pkg::POS_W-1:0]       pos_eff;
  logic [oli_pkg::DATA_W-1:0]      rd_data;
  oli_pkg::store_op_t              op;

  assign advance  = !out_valid_r || !out_stall;
  assign s1_load  = advance || !s1_valid_r;
  assign in_stall = !s1_load;
  assign cnt_p    = oli_pkg::POS_W'(count_r);

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    pos_eff    = '0;
    status_nxt = oli_pkg::ST_OOB;
    unique case (s1_kind_r)
      oli_pkg::KIND_INS_FRONT: pos_eff = '0;
      oli_pkg::KIND_INS_REAR:  pos_eff = cnt_p;
      oli_pkg::KIND_INS_AT:    pos_eff = oli_pkg::POS_W'(s1_pos_r);
      oli_pkg::KIND_DEL_FRONT: pos_eff = '0;
      oli_pkg::KIND_DEL_REAR:  pos_eff = cnt_p - oli_pkg::POS_W'(1);
      oli_pkg::KIND_DEL_AT:    pos_eff = oli_pkg::POS_W'(s1_pos_r);
      default:                 pos_eff = '0;
    endcase
    case (s1_kind_r) inside
      oli_pkg::KIND_INS_FRONT, oli_pkg::KIND_INS_REAR, oli_pkg::KIND_INS_AT: begin
        if (cnt_p >= CAP_P) begin
          status_nxt = oli_pkg::ST_FULL;
        end else if (pos_eff > cnt_p) begin
          status_nxt = oli_pkg::ST_OOB;
        end else begin
          status_nxt = oli_pkg::ST_OK;
          do_ins     = 1'b1;
        end
      end
      oli_pkg::KIND_DEL_FRONT, oli_pkg::KIND_DEL_REAR, oli_pkg::KIND_DEL_AT: begin
        if (count_r == '0) begin
          status_nxt = oli_pkg::ST_EMPTY;
        end else if (pos_eff >= cnt_p) begin
          status_nxt = oli_pkg::ST_OOB;
        end else begin
          status_nxt = oli_pkg::ST_OK;
          do_del     = 1'b1;
        end
      end
      default: status_nxt = oli_pkg::ST_OOB;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    item_nxt  = '0;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
      item_nxt  = s1_value_r;
    end else if (do_del) begin
      count_nxt = count_r - CNT_W'(1);
      item_nxt  = rd_data;
    end
  end

  always_comb begin
    op.we    = advance && s1_valid_r && (do_ins || do_del);
    op.ins   = do_ins;
    op.pos   = pos_eff;
    op.value = s1_value_r;
  end

  oli_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk     (clk),
    .op      (op),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          count_r <= count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_kind_r  <= in_kind;
      s1_value_r <= in_value;
      s1_pos_r   <= in_position;
    end
    if (advance && s1_valid_r) begin
      status_r <= status_nxt;
      item_r   <= item_nxt;
      length_r <= oli_pkg::LEN_W'(oli_pkg::POS_W'(count_nxt));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_item_value = item_r;
  assign out_length     = length_r;

endmodule

// ===== hw/rtl/oli_check.sv =====
// Port checker for the ordered list store and the bind that attaches it.
module oli_check #(
  parameter int CAPACITY = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [oli_pkg::KIND_W-1:0]    in_kind,
  input logic [oli_pkg::DATA_W-1:0]    in_value,
  input logic [oli_pkg::POS_IN_W-1:0]  in_position,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [oli_pkg::STAT_W-1:0]    out_status,
  input logic [oli_pkg::DATA_W-1:0]    out_item_value,
  input logic [oli_pkg::LEN_W-1:0]     out_length
);

  localparam logic [oli_pkg::LEN_W-1:0] CAP_LEN = oli_pkg::LEN_W'(CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_item_value) && $stable(out_length))
    else $error("Result word changed while stalled.");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_kind)
      && $stable(in_value) && $stable(in_position))
    else $error("Request word changed while stalled.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != oli_pkg::ST_OK |-> out_item_value == '0)
    else $error("Failed request returned a nonzero value.");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == oli_pkg::ST_FULL |-> out_length == CAP_LEN)
    else $error("Full status with length below capacity.");

  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("Input stalled while the result register is empty.");

endmodule

bind ordered_list_insert_delete oli_check #(.CAPACITY(CAPACITY)) u_oli_check (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the ordered list store with front, rear and indexed insert and delete.
`timescale 1ns / 1ps

module tb_top;

  localparam int CAPACITY        = 16;
  localparam int RANDOM_REQUESTS = 900;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int HOLD_AT_WORD    = 120;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 8;

  localparam logic [oli_pkg::KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [oli_pkg::KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

  localparam logic signed [oli_pkg::DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [oli_pkg::DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

  typedef struct {
    logic [oli_pkg::KIND_W-1:0]        kind;
    logic signed [oli_pkg::DATA_W-1:0] value;
    logic [oli_pkg::POS_IN_W-1:0]      position;
  } request_t;

  typedef struct {
    logic [oli_pkg::STAT_W-1:0]        status;
    logic signed [oli_pkg::DATA_W-1:0] item_value;
    logic [oli_pkg::LEN_W-1:0]         length;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [oli_pkg::KIND_W-1:0]        in_kind = '0;
  logic signed [oli_pkg::DATA_W-1:0] in_value = '0;
  logic [oli_pkg::POS_IN_W-1:0]      in_position = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [oli_pkg::STAT_W-1:0]        out_status;
  logic signed [oli_pkg::DATA_W-1:0] out_item_value;
  logic [oli_pkg::LEN_W-1:0]         out_length;

  request_t     request_q[$];
  list_result_t expected_results[$];

  logic signed [oli_pkg::DATA_W-1:0] list_entries [CAPACITY];
  int list_len = 0;
  int gen_len = 0;

  int total_requests = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int peak_length = 0;
  int cycle_count = 0;
  int hold_count = 0;
  logic hold_done = 1'b0;
  logic word_taken = 1'b0;
  int phase;

  ordered_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_item_value(out_item_value),
    .out_length(out_length)
  );

  always #4 clk = ~clk;

  function automatic void add_request(logic [oli_pkg::KIND_W-1:0] kind,
                                      logic signed [oli_pkg::DATA_W-1:0] value,
                                      logic [oli_pkg::POS_IN_W-1:0] position);
    request_t r;
    r.kind = kind;
    r.value = value;
    r.position = position;
    request_q.push_back(r);
    total_requests++;
    if (kind == oli_pkg::KIND_INS_FRONT || kind == oli_pkg::KIND_INS_REAR ||
        (kind == oli_pkg::KIND_INS_AT && int'(position) <= gen_len)) begin
      if (gen_len < CAPACITY) gen_len++;
    end else if (gen_len > 0 &&
                 (kind == oli_pkg::KIND_DEL_FRONT || kind == oli_pkg::KIND_DEL_REAR ||
                  (kind == oli_pkg::KIND_DEL_AT && int'(position) < gen_len))) begin
      gen_len--;
    end
  endfunction

  function automatic list_result_t apply_list_request(request_t r);
    list_result_t res;
    int at;
    int i;
    res.status = oli_pkg::ST_OOB;
    res.item_value = '0;
    at = int'(r.position);
    if (r.kind == oli_pkg::KIND_INS_FRONT || r.kind == oli_pkg::KIND_INS_REAR ||
        r.kind == oli_pkg::KIND_INS_AT) begin
      if (r.kind == oli_pkg::KIND_INS_FRONT) at = 0;
      if (r.kind == oli_pkg::KIND_INS_REAR) at = list_len;
      if (list_len >= CAPACITY) begin
        res.status = oli_pkg::ST_FULL;
      end else if (at <= list_len) begin
        for (i = list_len; i > at; i--) list_entries[i] = list_entries[i-1];
        list_entries[at] = r.value;
        list_len++;
        res.status = oli_pkg::ST_OK;
        res.item_value = r.value;
      end
    end else if (r.kind == oli_pkg::KIND_DEL_FRONT || r.kind == oli_pkg::KIND_DEL_REAR ||
                 r.kind == oli_pkg::KIND_DEL_AT) begin
      if (r.kind == oli_pkg::KIND_DEL_FRONT) at = 0;
      if (r.kind == oli_pkg::KIND_DEL_REAR) at = list_len - 1;
      if (list_len == 0) begin
        res.status = oli_pkg::ST_EMPTY;
      end else if (at < list_len) begin
        res.item_value = list_entries[at];
        for (i = at; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
        list_len--;
        res.status = oli_pkg::ST_OK;
      end
    end
    res.length = oli_pkg::LEN_W'(list_len);
    return res;
  endfunction

  always_comb begin
    phase = (total_requests == 0) ? 0 : (words_accepted * 4) / total_requests;
    if (phase > 3) phase = 3;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    request_t r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d value %0d length %0d",
                     out_status, out_item_value, out_length);
        end else begin
          exp_res = expected_results.pop_front();
          results_checked++;
          if (out_status !== exp_res.status || out_item_value !== exp_res.item_value ||
              out_length !== exp_res.length) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected status %0d value %0d length %0d, got %0d %0d %0d",
                       results_checked, exp_res.status, exp_res.item_value, exp_res.length,
                       out_status, out_item_value, out_length);
          end
          status_seen[exp_res.status]++;
          if (int'(exp_res.length) > peak_length) peak_length = int'(exp_res.length);
        end
      end
      if (in_valid && !in_stall) begin
        r.kind = in_kind;
        r.value = in_value;
        r.position = in_position;
        expected_results.push_back(apply_list_request(r));
        words_accepted++;
      end
      word_taken <= in_valid && !in_stall;
    end
  end

  always @(negedge clk) begin
    request_t r;
    int idle_pct;
    idle_pct = (phase == 1) ? 61 : (phase == 3) ? 25 : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        r = request_q.pop_front();
        in_valid <= 1'b1;
        in_kind <= r.kind;
        in_value <= r.value;
        in_position <= r.position;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!hold_done && words_accepted >= HOLD_AT_WORD) begin
      hold_count <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
    end
  end

  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (phase == 2) ? 61 : (phase == 3) ? 25 : 0;
    out_stall <= (hold_count != 0) || ($urandom_range(99) < stall_pct);
  end

  initial begin
    logic [oli_pkg::KIND_W-1:0] fill_kinds [3];
    logic [oli_pkg::KIND_W-1:0] del_kinds [3];
    logic signed [oli_pkg::DATA_W-1:0] value;
    logic [oli_pkg::POS_IN_W-1:0] position;
    int n;
    int ins_pct;
    int roll;

    fill_kinds[0] = oli_pkg::KIND_INS_FRONT;
    fill_kinds[1] = oli_pkg::KIND_INS_REAR;
    fill_kinds[2] = oli_pkg::KIND_INS_AT;
    del_kinds[0] = oli_pkg::KIND_DEL_FRONT;
    del_kinds[1] = oli_pkg::KIND_DEL_REAR;
    del_kinds[2] = oli_pkg::KIND_DEL_AT;

    add_request(oli_pkg::KIND_DEL_FRONT, 0, 0);
    add_request(oli_pkg::KIND_DEL_REAR, 32'sh1234, 0);
    add_request(oli_pkg::KIND_DEL_AT, 0, 63);
    add_request(oli_pkg::KIND_INS_AT, 7, 1);
    add_request(KIND_UNUSED_6, $urandom, 63);
    add_request(KIND_UNUSED_7, $urandom, 0);
    add_request(oli_pkg::KIND_INS_FRONT, VALUE_MAX, 0);
    add_request(oli_pkg::KIND_INS_REAR, VALUE_MIN, 0);
    add_request(oli_pkg::KIND_INS_AT, -1, 1);
    add_request(oli_pkg::KIND_INS_AT, 0, 3);
    add_request(oli_pkg::KIND_INS_AT, 5, 63);
    n = 0;
    while (gen_len < CAPACITY) begin
      add_request(fill_kinds[n % 3], $urandom, oli_pkg::POS_IN_W'(gen_len / 2));
      n++;
    end
    add_request(oli_pkg::KIND_INS_FRONT, 11, 0);
    add_request(oli_pkg::KIND_INS_AT, 12, 63);
    add_request(oli_pkg::KIND_DEL_AT, 0, oli_pkg::POS_IN_W'(CAPACITY));
    add_request(oli_pkg::KIND_DEL_AT, 0, 63);
    add_request(oli_pkg::KIND_DEL_AT, 0, 7);
    add_request(oli_pkg::KIND_DEL_REAR, 0, 0);
    add_request(oli_pkg::KIND_DEL_FRONT, 0, 0);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      ins_pct = ((n / 150) % 2 == 0) ? 65 : 35;
      roll = $urandom_range(99);
      if ($urandom_range(9) == 0) value = $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      else value = $urandom;
      if (roll < 4) begin
        add_request((roll < 2) ? KIND_UNUSED_6 : KIND_UNUSED_7, value,
                    oli_pkg::POS_IN_W'($urandom_range(63)));
      end else if ($urandom_range(99) < ins_pct) begin
        position = ($urandom_range(3) == 0) ? oli_pkg::POS_IN_W'($urandom_range(63))
                                            : oli_pkg::POS_IN_W'($urandom_range(gen_len));
        add_request(fill_kinds[$urandom_range(2)], value, position);
      end else begin
        if (gen_len == 0 || $urandom_range(3) == 0)
          position = oli_pkg::POS_IN_W'($urandom_range(63));
        else position = oli_pkg::POS_IN_W'($urandom_range(gen_len - 1));
        add_request(del_kinds[$urandom_range(2)], value, position);
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d requests checked over four handshake phases and a %0d-cycle output hold-off",
             results_checked, HOLD_CYCLES);
    $display("results ok/empty/out of bounds/full: %0d/%0d/%0d/%0d, peak length %0d",
             status_seen[oli_pkg::ST_OK], status_seen[oli_pkg::ST_EMPTY],
             status_seen[oli_pkg::ST_OOB], status_seen[oli_pkg::ST_FULL], peak_length);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
